@@ rtl/core/tpt_pkg.sv @@
`timescale 1ns / 1ps
package tpt_pkg;

  localparam int unsigned OPC_W     = 1;
  localparam int unsigned ZOOM_W    = 5;
  localparam int unsigned COORD_W   = 22;
  localparam int unsigned PAGE_W    = 12;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned SLOT_XY_W = 6;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned DIST_W    = 12;
  localparam int unsigned TOMB_W    = 13;
  localparam int unsigned KEY_W     = ZOOM_W + 2 * COORD_W;

  localparam logic [WORD_W-1:0] FNV_BASIS   = 32'd2166136261;
  localparam logic [WORD_W-1:0] FNV_PRIME   = 32'd16777619;
  localparam logic [WORD_W-1:0] VALUE_VALID = 32'h8000_0000;
  localparam logic [WORD_W-1:0] VALUE_TOMB  = 32'h4000_0000;
  localparam int unsigned       ZOOM_SHIFT  = 26;

  localparam logic [OPC_W-1:0] OPC_INSERT  = 1'b0;
  localparam logic [OPC_W-1:0] OPC_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;

  typedef logic [1:0] alu_op_t;
  localparam alu_op_t ALU_HASH  = 2'd0;
  localparam alu_op_t ALU_MUL   = 2'd1;
  localparam alu_op_t ALU_MULHI = 2'd2;
  localparam alu_op_t ALU_SUB   = 2'd3;

  typedef struct packed {
    alu_op_t           op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } alu_cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] res;
    logic              qbit;
  } alu_rsp_t;

endpackage

@@ rtl/core/tpt_req_if.sv @@
`timescale 1ns / 1ps
interface tpt_req_if;
  logic                          valid;
  logic                          ready;
  logic [tpt_pkg::OPC_W-1:0]     opcode;
  logic [tpt_pkg::ZOOM_W-1:0]    tile_zoom;
  logic [tpt_pkg::COORD_W-1:0]   tile_x;
  logic [tpt_pkg::COORD_W-1:0]   tile_y;
  logic [tpt_pkg::PAGE_W-1:0]    atlas_page;

  modport source (output valid, opcode, tile_zoom, tile_x, tile_y, atlas_page, input ready);
  modport sink   (input valid, opcode, tile_zoom, tile_x, tile_y, atlas_page, output ready);
endinterface

@@ rtl/core/tpt_rsp_if.sv @@
`timescale 1ns / 1ps
interface tpt_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [tpt_pkg::STATUS_W-1:0]    status;
  logic [tpt_pkg::SLOT_XY_W-1:0]   slot_x;
  logic [tpt_pkg::SLOT_XY_W-1:0]   slot_y;
  logic [tpt_pkg::WORD_W-1:0]      key_word0;
  logic [tpt_pkg::WORD_W-1:0]      key_word1;
  logic [tpt_pkg::WORD_W-1:0]      value_word;
  logic [tpt_pkg::DIST_W-1:0]      probe_distance;
  logic [tpt_pkg::TOMB_W-1:0]      tombstones;

  modport source (output valid, status, slot_x, slot_y, key_word0, key_word1, value_word,
                  probe_distance, tombstones, input ready);
  modport sink   (input valid, status, slot_x, slot_y, key_word0, key_word1, value_word,
                  probe_distance, tombstones, output ready);
endinterface

@@ rtl/core/tile_page_table_hash_slots_core.sv @@
`timescale 1ns / 1ps
// Tile page table: maps (zoom, x, y) keys to slots of a TABLE_WIDTH x TABLE_HEIGHT
// grid by open addressing with linear probing and tombstones.
// req carries one operation per beat (insert/refresh or release); rsp returns
// exactly one page-table write or status beat for each request beat.
// Per item: FNV-1a over zoom, x and y through the shared multiplier, then the home slot
// (a bit slice per grid axis when its size is a power of two, else through the same unit:
// reciprocal multiply, back-multiply, one compare and subtract), then the slot index
// y * TABLE_WIDTH + x formed in the same unit, one read of the slot memories and one check
// per probe, and a retire step.
// req turns ready again as the rsp beat turns valid, and req is ready only between
// items: a new request is not taken until the last one has retired.
// After reset the slot flags are swept clear with req not ready; the tombstone count
// resets to zero.
// rsp sits in an output register: a new request is taken while a beat waits, and
// the next beat holds in its retire step until rsp drains.
module tile_page_table_hash_slots_core #(
  parameter int unsigned TABLE_WIDTH  = 64,
  parameter int unsigned TABLE_HEIGHT = 64
) (
  input logic      clk,
  input logic      rst,
  tpt_req_if.sink   req,
  tpt_rsp_if.source rsp
);

  localparam int unsigned SLOTS  = TABLE_WIDTH * TABLE_HEIGHT;
  localparam int unsigned AW     = $clog2(SLOTS);
  localparam int unsigned XW     = $clog2(TABLE_WIDTH);
  localparam int unsigned YW     = $clog2(TABLE_HEIGHT);
  localparam int unsigned CW     = $clog2(SLOTS + 1);
  localparam bit          W_POW2 = ((TABLE_WIDTH & (TABLE_WIDTH - 1)) == 0);
  localparam bit          H_POW2 = ((TABLE_HEIGHT & (TABLE_HEIGHT - 1)) == 0);
  localparam logic [tpt_pkg::WORD_W-1:0] RECIP_W =
    tpt_pkg::WORD_W'((64'd1 << tpt_pkg::WORD_W) / TABLE_WIDTH);
  localparam logic [tpt_pkg::WORD_W-1:0] RECIP_H =
    tpt_pkg::WORD_W'((64'd1 << tpt_pkg::WORD_W) / TABLE_HEIGHT);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_DIVX  = 4'd3;
  localparam logic [3:0] S_DIVY  = 4'd4;
  localparam logic [3:0] S_HOME  = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]                    state;
  logic [4:0]                    step;
  logic [tpt_pkg::WORD_W-1:0]    acc;
  logic [tpt_pkg::WORD_W-1:0]    quo;
  logic [tpt_pkg::WORD_W-1:0]    rest;
  logic [tpt_pkg::OPC_W-1:0]     op;
  logic [tpt_pkg::ZOOM_W-1:0]    zoom;
  logic [tpt_pkg::COORD_W-1:0]   tx;
  logic [tpt_pkg::COORD_W-1:0]   ty;
  logic [tpt_pkg::PAGE_W-1:0]    page;
  logic [AW-1:0]                 p;
  logic [XW-1:0]                 px;
  logic [YW-1:0]                 py;
  logic [AW-1:0]                 hops;
  logic                          found;
  logic                          have_tomb;
  logic                          have_free;
  logic [AW-1:0]                 tomb;
  logic [XW-1:0]                 tomb_x;
  logic [YW-1:0]                 tomb_y;
  logic [AW-1:0]                 tomb_dist;
  logic [CW-1:0]                 tcount;
  logic [CW-1:0]                 tcount_next;

  tpt_pkg::alu_cmd_t             alu_cmd;
  tpt_pkg::alu_rsp_t             alu_rsp;

  logic [tpt_pkg::KEY_W-1:0]     key;
  logic [tpt_pkg::KEY_W-1:0]     key_rdata;
  logic [1:0]                    flag_rdata;
  logic                          key_we;
  logic                          flag_we;
  logic [AW-1:0]                 wr_addr;
  logic [AW-1:0]                 flag_waddr;
  logic [1:0]                    flag_wdata;
  logic                          retire;

  logic [tpt_pkg::STATUS_W-1:0]  o_status;
  logic [XW-1:0]                 o_x;
  logic [YW-1:0]                 o_y;
  logic [tpt_pkg::WORD_W-1:0]    o_k0;
  logic [tpt_pkg::WORD_W-1:0]    o_k1;
  logic [tpt_pkg::WORD_W-1:0]    o_val;
  logic [AW-1:0]                 o_dist;

  logic                          live;
  logic                          used;
  logic                          last_probe;

  assign key        = {zoom, tx, ty};
  assign live       = flag_rdata[1];
  assign used       = flag_rdata[0];
  assign last_probe = (hops == AW'(SLOTS - 1));
  assign req.ready  = (state == S_IDLE);
  assign retire     = (state == S_DONE) && (!rsp.valid || rsp.ready);

  tpt_alu u_alu (
    .cmd (alu_cmd),
    .rsp (alu_rsp)
  );

  tpt_ram #(
    .WIDTH (tpt_pkg::KEY_W),
    .DEPTH (SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_addr),
    .wdata (key),
    .raddr (p),
    .rdata (key_rdata)
  );

  tpt_ram #(
    .WIDTH (2),
    .DEPTH (SLOTS)
  ) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .raddr (p),
    .rdata (flag_rdata)
  );

  always_comb begin
    alu_cmd = '0;
    unique case (state)
      S_HASH: begin
        alu_cmd.op = tpt_pkg::ALU_HASH;
        alu_cmd.a  = acc;
        if (step == 5'd0) begin
          alu_cmd.b = tpt_pkg::WORD_W'(zoom);
        end else if (step == 5'd1) begin
          alu_cmd.b = tpt_pkg::WORD_W'(tx);
        end else begin
          alu_cmd.b = tpt_pkg::WORD_W'(ty);
        end
      end
      S_DIVX: begin
        if (step == 5'd0) begin
          alu_cmd.op = tpt_pkg::ALU_MULHI;
          alu_cmd.a  = acc;
          alu_cmd.b  = RECIP_W;
        end else if (step == 5'd1) begin
          alu_cmd.op = tpt_pkg::ALU_MUL;
          alu_cmd.a  = quo;
          alu_cmd.b  = tpt_pkg::WORD_W'(TABLE_WIDTH);
        end else begin
          alu_cmd.op = tpt_pkg::ALU_SUB;
          alu_cmd.a  = rest;
          alu_cmd.b  = tpt_pkg::WORD_W'(TABLE_WIDTH);
        end
      end
      S_DIVY: begin
        if (step == 5'd0) begin
          alu_cmd.op = tpt_pkg::ALU_MULHI;
          alu_cmd.a  = acc;
          alu_cmd.b  = RECIP_H;
        end else if (step == 5'd1) begin
          alu_cmd.op = tpt_pkg::ALU_MUL;
          alu_cmd.a  = quo;
          alu_cmd.b  = tpt_pkg::WORD_W'(TABLE_HEIGHT);
        end else begin
          alu_cmd.op = tpt_pkg::ALU_SUB;
          alu_cmd.a  = rest;
          alu_cmd.b  = tpt_pkg::WORD_W'(TABLE_HEIGHT);
        end
      end
      S_HOME: begin
        alu_cmd.op = tpt_pkg::ALU_MUL;
        alu_cmd.a  = tpt_pkg::WORD_W'(py);
        alu_cmd.b  = tpt_pkg::WORD_W'(TABLE_WIDTH);
      end
      default: begin
        alu_cmd = '0;
      end
    endcase
  end

  always_comb begin
    o_status    = tpt_pkg::ST_FULL;
    o_x         = '0;
    o_y         = '0;
    o_k0        = '0;
    o_k1        = '0;
    o_val       = '0;
    o_dist      = '0;
    wr_addr     = p;
    key_we      = 1'b0;
    flag_we     = 1'b0;
    flag_wdata  = 2'b00;
    tcount_next = tcount;
    if (op == tpt_pkg::OPC_RELEASE) begin
      if (found) begin
        o_status    = tpt_pkg::ST_RELEASED;
        o_x         = px;
        o_y         = py;
        o_val       = tpt_pkg::VALUE_TOMB;
        flag_we     = retire;
        flag_wdata  = 2'b01;
        tcount_next = tcount + CW'(1);
      end else begin
        o_status = tpt_pkg::ST_MISS;
      end
    end else begin
      if (found || have_tomb || have_free) begin
        o_k0  = {1'b0, zoom, 4'b0000, tx};
        o_k1  = {10'd0, ty};
        o_val = tpt_pkg::VALUE_VALID | tpt_pkg::WORD_W'(page);
      end
      if (found) begin
        o_status = tpt_pkg::ST_PRESENT;
        o_x      = px;
        o_y      = py;
        o_dist   = hops;
      end else if (have_tomb) begin
        o_status   = tpt_pkg::ST_INSERTED;
        o_x        = tomb_x;
        o_y        = tomb_y;
        o_dist     = tomb_dist;
        wr_addr    = tomb;
        key_we     = retire;
        flag_we    = retire;
        flag_wdata = 2'b11;
        if (tcount != '0) begin
          tcount_next = tcount - CW'(1);
        end
      end else if (have_free) begin
        o_status   = tpt_pkg::ST_INSERTED;
        o_x        = px;
        o_y        = py;
        o_dist     = hops;
        key_we     = retire;
        flag_we    = retire;
        flag_wdata = 2'b11;
      end
    end
    flag_waddr = wr_addr;
    if (state == S_CLEAR) begin
      flag_we    = 1'b1;
      flag_waddr = p;
      flag_wdata = 2'b00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      step      <= '0;
      p         <= '0;
      tcount    <= '0;
      rsp.valid <= 1'b0;
      found     <= 1'b0;
      have_tomb <= 1'b0;
      have_free <= 1'b0;
    end else begin
      if (retire) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (p == AW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
          p <= p + AW'(1);
        end
        S_IDLE: begin
          if (req.valid) begin
            op    <= req.opcode;
            zoom  <= req.tile_zoom;
            tx    <= req.tile_x;
            ty    <= req.tile_y;
            page  <= req.atlas_page;
            acc   <= tpt_pkg::FNV_BASIS;
            step  <= '0;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          acc <= alu_rsp.res;
          if (step == 5'd2) begin
            step  <= '0;
            state <= S_DIVX;
          end else begin
            step <= step + 5'd1;
          end
        end
        S_DIVX: begin
          if (W_POW2) begin
            px    <= acc[XW-1:0];
            acc   <= acc >> XW;
            state <= S_DIVY;
          end else if (step == 5'd0) begin
            quo  <= alu_rsp.res;
            step <= 5'd1;
          end else if (step == 5'd1) begin
            rest <= acc - alu_rsp.res;
            step <= 5'd2;
          end else begin
            px    <= alu_rsp.res[XW-1:0];
            acc   <= quo + tpt_pkg::WORD_W'(alu_rsp.qbit);
            step  <= '0;
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (H_POW2) begin
            py    <= acc[YW-1:0];
            state <= S_HOME;
          end else if (step == 5'd0) begin
            quo  <= alu_rsp.res;
            step <= 5'd1;
          end else if (step == 5'd1) begin
            rest <= acc - alu_rsp.res;
            step <= 5'd2;
          end else begin
            py    <= alu_rsp.res[YW-1:0];
            step  <= '0;
            state <= S_HOME;
          end
        end
        S_HOME: begin
          p         <= alu_rsp.res[AW-1:0] + AW'(px);
          hops      <= '0;
          found     <= 1'b0;
          have_tomb <= 1'b0;
          have_free <= 1'b0;
          state     <= S_RD;
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (live && (key_rdata == key)) begin
            found <= 1'b1;
            state <= S_DONE;
          end else if (!live && !used) begin
            have_free <= 1'b1;
            state     <= S_DONE;
          end else begin
            if (!live && !have_tomb) begin
              have_tomb <= 1'b1;
              tomb      <= p;
              tomb_x    <= px;
              tomb_y    <= py;
              tomb_dist <= hops;
            end
            if (last_probe) begin
              state <= S_DONE;
            end else begin
              hops  <= hops + AW'(1);
              state <= S_RD;
              if (p == AW'(SLOTS - 1)) begin
                p <= '0;
              end else begin
                p <= p + AW'(1);
              end
              if (px == XW'(TABLE_WIDTH - 1)) begin
                px <= '0;
                if (py == YW'(TABLE_HEIGHT - 1)) begin
                  py <= '0;
                end else begin
                  py <= py + YW'(1);
                end
              end else begin
                px <= px + XW'(1);
              end
            end
          end
        end
        S_DONE: begin
          if (retire) begin
            tcount <= tcount_next;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      rsp.status         <= o_status;
      rsp.slot_x         <= o_x[tpt_pkg::SLOT_XY_W-1:0];
      rsp.slot_y         <= o_y[tpt_pkg::SLOT_XY_W-1:0];
      rsp.key_word0      <= o_k0;
      rsp.key_word1      <= o_k1;
      rsp.value_word     <= o_val;
      rsp.probe_distance <= o_dist[tpt_pkg::DIST_W-1:0];
      rsp.tombstones     <= tcount_next[tpt_pkg::TOMB_W-1:0];
    end
  end

endmodule

@@ rtl/core/tpt_ram.sv @@
`timescale 1ns / 1ps
module tpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/tpt_alu.sv @@
`timescale 1ns / 1ps
module tpt_alu (
  input  tpt_pkg::alu_cmd_t cmd,
  output tpt_pkg::alu_rsp_t rsp
);

  localparam int unsigned PW = 2 * tpt_pkg::WORD_W;

  logic [tpt_pkg::WORD_W-1:0] mul_a;
  logic [tpt_pkg::WORD_W-1:0] mul_b;
  logic [PW-1:0]              prod;
  logic [tpt_pkg::WORD_W:0]   diff;
  logic                       ge;

  always_comb begin
    mul_a = cmd.a;
    mul_b = cmd.b;
    if (cmd.op == tpt_pkg::ALU_HASH) begin
      mul_a = cmd.a ^ cmd.b;
      mul_b = tpt_pkg::FNV_PRIME;
    end
    prod = PW'(mul_a) * PW'(mul_b);
    diff = {1'b0, cmd.a} - {1'b0, cmd.b};
    ge   = !diff[tpt_pkg::WORD_W];
  end

  always_comb begin
    rsp = '0;
    unique case (cmd.op)
      tpt_pkg::ALU_HASH, tpt_pkg::ALU_MUL: begin
        rsp.res = prod[tpt_pkg::WORD_W-1:0];
      end
      tpt_pkg::ALU_MULHI: begin
        rsp.res = prod[PW-1:tpt_pkg::WORD_W];
      end
      tpt_pkg::ALU_SUB: begin
        rsp.res  = ge ? diff[tpt_pkg::WORD_W-1:0] : cmd.a;
        rsp.qbit = ge;
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

endmodule
